### src/i2cra_pkg.sv
// shared types and constants for the i2c register access master
`timescale 1ns / 1ps

package i2cra_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_SLAVE_ADDR  = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_HALF_BIT    = 2'd2;

  localparam logic [6:0]  SLAVE_ADDR_RST  = 7'd115;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] HALF_BIT_RST    = 16'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic       status;
    logic       busy_res;
  } out_item_t;

endpackage

### src/i2c_register_access_master.sv
// i2c register access master: one bus time quantum per input transfer
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_ready       in_item_t (op, addresses, sda sample)
//   out_      output     out_valid / out_ready     out_item_t (bus drive, byte, done)
//   apb       input      psel / penable / pwrite   paddr, pwdata, prdata
//
// one quantum per clock: the bus state machine and its counters update in the
// same cycle the transfer is accepted, and the result lands in the output register
// a new quantum is taken whenever the output register is empty or being drained
// an output stall holds the result and blocks input until it is taken
// reset (rst_n low, synchronous) puts the bus idle and loads the register defaults
`timescale 1ns / 1ps

module i2c_register_access_master import i2cra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ST_HI    = 4'd1;
  localparam logic [3:0] PH_ST_LO    = 4'd2;
  localparam logic [3:0] PH_RS_PRE   = 4'd3;
  localparam logic [3:0] PH_TX_L     = 4'd4;
  localparam logic [3:0] PH_TX_H     = 4'd5;
  localparam logic [3:0] PH_ACK_L    = 4'd6;
  localparam logic [3:0] PH_ACK_H    = 4'd7;
  localparam logic [3:0] PH_ACK_POLL = 4'd8;
  localparam logic [3:0] PH_RX_L     = 4'd9;
  localparam logic [3:0] PH_RX_H     = 4'd10;
  localparam logic [3:0] PH_MA_L     = 4'd11;
  localparam logic [3:0] PH_MA_H     = 4'd12;
  localparam logic [3:0] PH_SP_L     = 4'd13;
  localparam logic [3:0] PH_SP_M     = 4'd14;
  localparam logic [3:0] PH_SP_H     = 4'd15;

  localparam logic [1:0] STG_ADDR = 2'd0;
  localparam logic [1:0] STG_REG  = 2'd1;
  localparam logic [1:0] STG_DATA = 2'd2;
  localparam logic [1:0] STG_RX   = 2'd3;

  logic [6:0]  slave_addr_r;
  logic [7:0]  ack_timeout_r;
  logic [15:0] half_bit_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  wait_count_r, wait_count_nxt;
  logic [15:0] qcount_r, qcount_nxt;
  logic        lat_write_r, lat_write_nxt;
  logic [7:0]  lat_reg_r, lat_reg_nxt;
  logic [7:0]  lat_data_r, lat_data_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic        addr_err_r, addr_err_nxt;

  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic        in_accept;
  logic        cfg_write;
  logic [15:0] half_bit_eff;
  logic [15:0] qcount_inc;
  logic        slot_end;
  logic [3:0]  bit_inc;
  logic [7:0]  rx_shift;
  logic [7:0]  bytes_dec;
  logic        ack_timed_out;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= SLAVE_ADDR_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      half_bit_r    <= HALF_BIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SLAVE_ADDR:  slave_addr_r  <= pwdata[6:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= pwdata[7:0];
        REG_HALF_BIT:    half_bit_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLAVE_ADDR:  prdata = {25'd0, slave_addr_r};
      REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_r};
      REG_HALF_BIT:    prdata = {16'd0, half_bit_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign half_bit_eff  = (half_bit_r == 16'd0) ? 16'd1 : half_bit_r;
  assign qcount_inc    = qcount_r + 16'd1;
  assign slot_end      = qcount_inc >= half_bit_eff;
  assign bit_inc       = bit_count_r + 4'd1;
  assign rx_shift      = {shift_r[6:0], in_data.sda_in};
  assign bytes_dec     = bytes_left_r - 8'd1;
  assign ack_timed_out = wait_count_r >= ack_timeout_r;

  // bus drive for the current phase, plus the next phase and counter values
  always_comb begin
    out_nxt = '0;
    out_nxt.scl_level = 1'b1;
    out_nxt.sda_level = 1'b1;
    out_nxt.busy_res  = 1'b1;
    case (phase_r)
      PH_IDLE:     out_nxt.busy_res = 1'b0;
      PH_ST_LO:    out_nxt.sda_level = 1'b0;
      PH_RS_PRE:   out_nxt.scl_level = 1'b0;
      PH_TX_L: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = shift_r[7];
      end
      PH_TX_H:     out_nxt.sda_level = shift_r[7];
      PH_ACK_L, PH_RX_L: begin
        out_nxt.scl_level    = 1'b0;
        out_nxt.sda_released = 1'b1;
      end
      PH_ACK_H, PH_ACK_POLL, PH_RX_H: out_nxt.sda_released = 1'b1;
      PH_MA_L: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = (bytes_left_r == 8'd1);
      end
      PH_MA_H:     out_nxt.sda_level = (bytes_left_r == 8'd1);
      PH_SP_L: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = 1'b0;
      end
      PH_SP_M:     out_nxt.sda_level = 1'b0;
      default: ;
    endcase

    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    wait_count_nxt = wait_count_r;
    qcount_nxt     = slot_end ? 16'd0 : qcount_inc;
    lat_write_nxt  = lat_write_r;
    lat_reg_nxt    = lat_reg_r;
    lat_data_nxt   = lat_data_r;
    stage_nxt      = stage_r;
    addr_err_nxt   = addr_err_r;

    case (phase_r)
      PH_IDLE: begin
        qcount_nxt = qcount_r;
        if (in_data.op == OP_WRITE || in_data.op == OP_READ) begin
          lat_write_nxt  = (in_data.op == OP_WRITE);
          lat_reg_nxt    = in_data.target_reg;
          lat_data_nxt   = in_data.write_data;
          bytes_left_nxt = in_data.read_length;
          stage_nxt      = STG_ADDR;
          addr_err_nxt   = 1'b0;
          phase_nxt      = PH_ST_HI;
          qcount_nxt     = 16'd0;
        end
      end
      PH_ST_HI: if (slot_end) phase_nxt = PH_ST_LO;
      PH_ST_LO: if (slot_end) begin
        shift_nxt     = {slave_addr_r, stage_r == STG_RX};
        bit_count_nxt = 4'd0;
        phase_nxt     = PH_TX_L;
      end
      PH_RS_PRE: if (slot_end) begin
        stage_nxt = STG_RX;
        phase_nxt = PH_ST_HI;
      end
      PH_TX_L:  if (slot_end) phase_nxt = PH_TX_H;
      PH_TX_H: if (slot_end) begin
        shift_nxt     = {shift_r[6:0], 1'b0};
        bit_count_nxt = bit_inc;
        if (bit_inc >= 4'd8) begin
          wait_count_nxt = 8'd0;
          phase_nxt      = PH_ACK_L;
        end else begin
          phase_nxt = PH_TX_L;
        end
      end
      PH_ACK_L: if (slot_end) phase_nxt = PH_ACK_H;
      PH_ACK_H: if (slot_end) phase_nxt = PH_ACK_POLL;
      PH_ACK_POLL: begin
        qcount_nxt = qcount_r;
        if (!in_data.sda_in || (ack_timed_out && stage_r != STG_ADDR)) begin
          // acknowledge seen, or a timeout that does not abort
          qcount_nxt = 16'd0;
          case (stage_r)
            STG_ADDR: begin
              stage_nxt     = STG_REG;
              shift_nxt     = lat_reg_r;
              bit_count_nxt = 4'd0;
              phase_nxt     = PH_TX_L;
            end
            STG_REG: begin
              if (lat_write_r) begin
                stage_nxt     = STG_DATA;
                shift_nxt     = lat_data_r;
                bit_count_nxt = 4'd0;
                phase_nxt     = PH_TX_L;
              end else begin
                phase_nxt = PH_RS_PRE;
              end
            end
            STG_DATA: phase_nxt = PH_SP_L;
            default: begin
              if (bytes_left_r == 8'd0) begin
                phase_nxt = PH_SP_L;
              end else begin
                shift_nxt     = 8'd0;
                bit_count_nxt = 4'd0;
                phase_nxt     = PH_RX_L;
              end
            end
          endcase
        end else if (ack_timed_out) begin
          addr_err_nxt = 1'b1;
          phase_nxt    = PH_SP_L;
          qcount_nxt   = 16'd0;
        end else begin
          wait_count_nxt = wait_count_r + 8'd1;
        end
      end
      PH_RX_L: if (slot_end) phase_nxt = PH_RX_H;
      PH_RX_H: if (slot_end) begin
        shift_nxt     = rx_shift;
        bit_count_nxt = bit_inc;
        if (bit_inc >= 4'd8) begin
          out_nxt.byte_valid = 1'b1;
          out_nxt.read_byte  = rx_shift;
          out_nxt.last_byte  = (bytes_left_r == 8'd1);
          phase_nxt          = PH_MA_L;
        end else begin
          phase_nxt = PH_RX_L;
        end
      end
      PH_MA_L: if (slot_end) phase_nxt = PH_MA_H;
      PH_MA_H: if (slot_end) begin
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 8'd0) begin
          phase_nxt = PH_SP_L;
        end else begin
          shift_nxt     = 8'd0;
          bit_count_nxt = 4'd0;
          phase_nxt     = PH_RX_L;
        end
      end
      PH_SP_L: if (slot_end) phase_nxt = PH_SP_M;
      PH_SP_M: if (slot_end) phase_nxt = PH_SP_H;
      PH_SP_H: if (slot_end) begin
        out_nxt.done_res = 1'b1;
        out_nxt.status   = addr_err_r;
        phase_nxt        = PH_IDLE;
      end
      default: begin
        phase_nxt  = PH_IDLE;
        qcount_nxt = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      wait_count_r <= 8'd0;
      qcount_r     <= 16'd0;
      lat_write_r  <= 1'b0;
      lat_reg_r    <= 8'd0;
      lat_data_r   <= 8'd0;
      stage_r      <= STG_ADDR;
      addr_err_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r      <= phase_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        wait_count_r <= wait_count_nxt;
        qcount_r     <= qcount_nxt;
        lat_write_r  <= lat_write_nxt;
        lat_reg_r    <= lat_reg_nxt;
        lat_data_r   <= lat_data_nxt;
        stage_r      <= stage_nxt;
        addr_err_r   <= addr_err_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= out_nxt;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> out_r.busy_res)
    else $error("done reported outside a transaction");

  a_byte_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.byte_valid |-> out_r.sda_released && !out_r.done_res)
    else $error("received byte while sda driven");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> out_r.done_res)
    else $error("status without done");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_IDLE && (in_data.op == OP_WRITE || in_data.op == OP_READ)
    |=> phase_r == PH_ST_HI && qcount_r == 16'd0)
    else $error("start not entered");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(phase_r) && $stable(qcount_r))
    else $error("state moved without a transfer");

endmodule

### tb/i2c_register_access_master_tb.sv
// self-checking testbench for the i2c register access master: bus engine predictor and scoreboard
`timescale 1ns / 1ps

module i2c_register_access_master_tb;
  import i2cra_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_HI, PH_ST_LO, PH_RS_PRE, PH_TX_L, PH_TX_H, PH_ACK_L, PH_ACK_H,
    PH_ACK_POLL, PH_RX_L, PH_RX_H, PH_MA_L, PH_MA_H, PH_SP_L, PH_SP_M, PH_SP_H
  } bus_phase_e;

  typedef enum logic [1:0] {SEG_ADDR, SEG_REG, SEG_DATA, SEG_READ} segment_e;

  class bus_result_board;
    logic [6:0]  slave_addr;
    logic [7:0]  ack_limit;
    logic [15:0] half_bit;
    bus_phase_e  phase;
    segment_e    seg;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [7:0]  bytes_left;
    logic [7:0]  poll_cnt;
    logic [15:0] quanta;
    logic [1:0]  txn_op;
    logic [7:0]  txn_reg;
    logic [7:0]  txn_data;
    logic        addr_refused;
    out_item_t   expected_quanta[$];
    int          errors;
    int          checked;
    int          txn_done;
    int          refusals;
    int          bytes_read;

    function new();
      slave_addr = SLAVE_ADDR_RST;
      ack_limit = ACK_TIMEOUT_RST;
      half_bit = HALF_BIT_RST;
      phase = PH_IDLE;
      seg = SEG_ADDR;
      bit_cnt = '0;
      shifter = '0;
      bytes_left = '0;
      poll_cnt = '0;
      quanta = '0;
      txn_op = OP_TICK;
      txn_reg = '0;
      txn_data = '0;
      addr_refused = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SLAVE_ADDR: slave_addr = value[6:0];
        REG_ACK_TIMEOUT: ack_limit = value[7:0];
        REG_HALF_BIT: half_bit = value[15:0];
        default: ;
      endcase
    endfunction

    function void goto(bus_phase_e p);
      phase = p;
      quanta = '0;
    endfunction

    function bit slot_done();
      logic [15:0] lim;
      lim = (half_bit == 16'd0) ? 16'd1 : half_bit;
      quanta = quanta + 16'd1;
      if (quanta >= lim) begin
        quanta = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void load_byte(logic [7:0] b);
      shifter = b;
      bit_cnt = '0;
      goto(PH_TX_L);
    endfunction

    function void next_segment();
      case (seg)
        SEG_ADDR: begin
          seg = SEG_REG;
          load_byte(txn_reg);
        end
        SEG_REG: begin
          if (txn_op == OP_WRITE) begin
            seg = SEG_DATA;
            load_byte(txn_data);
          end else begin
            goto(PH_RS_PRE);
          end
        end
        SEG_DATA: goto(PH_SP_L);
        default: begin
          if (bytes_left == 8'd0) begin
            goto(PH_SP_L);
          end else begin
            shifter = '0;
            bit_cnt = '0;
            goto(PH_RX_L);
          end
        end
      endcase
    endfunction

    function void take_quantum(in_item_t it);
      out_item_t want;
      want = '0;
      want.scl_level = 1'b1;
      want.sda_level = 1'b1;
      want.busy_res = 1'b1;
      case (phase)
        PH_IDLE: want.busy_res = 1'b0;
        PH_ST_LO: want.sda_level = 1'b0;
        PH_RS_PRE: want.scl_level = 1'b0;
        PH_TX_L: begin
          want.scl_level = 1'b0;
          want.sda_level = shifter[7];
        end
        PH_TX_H: want.sda_level = shifter[7];
        PH_ACK_L, PH_RX_L: begin
          want.scl_level = 1'b0;
          want.sda_released = 1'b1;
        end
        PH_ACK_H, PH_ACK_POLL, PH_RX_H: want.sda_released = 1'b1;
        PH_MA_L: begin
          want.scl_level = 1'b0;
          want.sda_level = (bytes_left == 8'd1);
        end
        PH_MA_H: want.sda_level = (bytes_left == 8'd1);
        PH_SP_L: begin
          want.scl_level = 1'b0;
          want.sda_level = 1'b0;
        end
        PH_SP_M: want.sda_level = 1'b0;
        default: ;
      endcase

      case (phase)
        PH_IDLE: begin
          if (it.op == OP_WRITE || it.op == OP_READ) begin
            txn_op = it.op;
            txn_reg = it.target_reg;
            txn_data = it.write_data;
            bytes_left = it.read_length;
            seg = SEG_ADDR;
            addr_refused = 1'b0;
            goto(PH_ST_HI);
          end
        end
        PH_ST_HI: if (slot_done()) goto(PH_ST_LO);
        PH_ST_LO: if (slot_done()) load_byte({slave_addr, seg == SEG_READ});
        PH_RS_PRE: begin
          if (slot_done()) begin
            seg = SEG_READ;
            goto(PH_ST_HI);
          end
        end
        PH_TX_L: if (slot_done()) goto(PH_TX_H);
        PH_TX_H: begin
          if (slot_done()) begin
            shifter = {shifter[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              poll_cnt = '0;
              goto(PH_ACK_L);
            end else begin
              goto(PH_TX_L);
            end
          end
        end
        PH_ACK_L: if (slot_done()) goto(PH_ACK_H);
        PH_ACK_H: if (slot_done()) goto(PH_ACK_POLL);
        PH_ACK_POLL: begin
          if (!it.sda_in) begin
            next_segment();
          end else if (poll_cnt >= ack_limit) begin
            if (seg == SEG_ADDR) begin
              addr_refused = 1'b1;
              goto(PH_SP_L);
            end else begin
              next_segment();
            end
          end else begin
            poll_cnt = poll_cnt + 8'd1;
          end
        end
        PH_RX_L: if (slot_done()) goto(PH_RX_H);
        PH_RX_H: begin
          if (slot_done()) begin
            shifter = {shifter[6:0], it.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              want.byte_valid = 1'b1;
              want.read_byte = shifter;
              want.last_byte = (bytes_left == 8'd1);
              bytes_read++;
              goto(PH_MA_L);
            end else begin
              goto(PH_RX_L);
            end
          end
        end
        PH_MA_L: if (slot_done()) goto(PH_MA_H);
        PH_MA_H: begin
          if (slot_done()) begin
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
              goto(PH_SP_L);
            end else begin
              shifter = '0;
              bit_cnt = '0;
              goto(PH_RX_L);
            end
          end
        end
        PH_SP_L: if (slot_done()) goto(PH_SP_M);
        PH_SP_M: if (slot_done()) goto(PH_SP_H);
        PH_SP_H: begin
          if (slot_done()) begin
            want.done_res = 1'b1;
            want.status = addr_refused;
            txn_done++;
            if (addr_refused) refusals++;
            goto(PH_IDLE);
          end
        end
        default: goto(PH_IDLE);
      endcase
      expected_quanta.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void match_quantum(out_item_t got);
      out_item_t want;
      if (expected_quanta.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t unexpected transfer: expected none, actual %h", $time, got);
        return;
      end
      want = expected_quanta.pop_front();
      checked++;
      compare("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare("sda_released", 8'(want.sda_released), 8'(got.sda_released));
      compare("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare("read_byte", want.read_byte, got.read_byte);
      compare("last_byte", 8'(want.last_byte), 8'(got.last_byte));
      compare("done_res", 8'(want.done_res), 8'(got.done_res));
      compare("status", 8'(want.status), 8'(got.status));
      compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bus_result_board board = new();
  int send_gap = 0;
  int recv_stall = 0;
  int late_ack_pct = 30;
  bit refuse_addr = 1'b0;

  i2c_register_access_master DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
      if (out_valid && out_ready) board.match_quantum(out_data);
    end
  end

  initial begin
    #2_000_000;
    $display("i2c_register_access_master_tb: errors");
    $finish;
  end

  // slave-like bus behavior with random content, plus stray ops
  function automatic in_item_t make_quantum(bit may_start);
    in_item_t it;
    it.op = OP_TICK;
    it.target_reg = 8'($urandom);
    it.write_data = 8'($urandom);
    it.read_length = 8'($urandom_range(4));
    it.sda_in = 1'($urandom);
    if (board.phase == PH_IDLE) begin
      if (may_start && $urandom_range(99) < 35) begin
        it.op = $urandom_range(1) ? OP_READ : OP_WRITE;
        refuse_addr = ($urandom_range(99) < 10);
      end else if ($urandom_range(99) < 5) begin
        it.op = OP_UNUSED;
      end
    end else begin
      if ($urandom_range(99) < 4) it.op = 2'($urandom);
      if (board.phase == PH_ACK_POLL)
        it.sda_in = (board.seg == SEG_ADDR) ? refuse_addr : ($urandom_range(99) < late_ack_pct);
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_quantum(it);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_quanta.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    while (board.phase != PH_IDLE) send_item(make_quantum(1'b0));
    hold_until_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(logic [6:0] addr, logic [7:0] timeout, logic [15:0] half);
    settle();
    write_reg(REG_SLAVE_ADDR, {25'd0, addr});
    write_reg(REG_ACK_TIMEOUT, {24'd0, timeout});
    write_reg(REG_HALF_BIT, {16'd0, half});
  endtask

  task automatic run_txn(logic [1:0] op, logic [7:0] regn, logic [7:0] data,
                         logic [7:0] len, bit refuse, int late_pct);
    in_item_t it;
    refuse_addr = refuse;
    late_ack_pct = late_pct;
    it = make_quantum(1'b0);
    it.op = op;
    it.target_reg = regn;
    it.write_data = data;
    it.read_length = len;
    send_item(it);
    // start while busy is dropped
    it = make_quantum(1'b0);
    it.op = OP_READ;
    send_item(it);
    while (board.phase != PH_IDLE) send_item(make_quantum(1'b0));
  endtask

  task automatic run_random(int count);
    late_ack_pct = 30;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(199) == 0) hold_until_drained();
      send_item(make_quantum(1'b1));
    end
    settle();
  endtask

  initial begin
    in_item_t it;
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap = 21;
    recv_stall = 85;
    run_txn(OP_WRITE, 8'h00, 8'hFF, 8'd0, 1'b0, 0);
    run_txn(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0, 0);
    run_txn(OP_READ, 8'hA5, 8'h5A, 8'd0, 1'b0, 0);
    run_txn(OP_READ, 8'h3C, 8'hC3, 8'd1, 1'b0, 0);
    it = make_quantum(1'b0);
    it.op = OP_UNUSED;
    send_item(it);
    send_item(make_quantum(1'b0));

    // zero timeout and zero half bit
    configure(7'd0, 8'd0, 16'd0);
    run_txn(OP_WRITE, 8'h55, 8'hAA, 8'd0, 1'b0, 100);
    run_txn(OP_READ, 8'hAA, 8'h55, 8'd2, 1'b1, 0);
    run_txn(OP_READ, 8'h0F, 8'hF0, 8'd3, 1'b0, 50);
    run_random(80);

    send_gap = 85;
    recv_stall = 21;
    configure(7'd127, 8'd255, 16'd2);
    run_random(60);
    configure(7'($urandom), 8'($urandom_range(1, 20)), 16'd1);
    run_random(60);

    // longest half bit: only idle quanta fit in the run
    configure(7'($urandom), 8'($urandom_range(1, 255)), 16'hFFFF);
    repeat (20) send_item(make_quantum(1'b0));

    send_gap = 0;
    recv_stall = 0;
    configure(7'($urandom), 8'($urandom_range(1, 8)), 16'd3);
    run_random(50);

    in_valid <= 1'b0;
    guard = 0;
    while (board.expected_quanta.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (board.expected_quanta.size() != 0) begin
      board.errors++;
      $display("%0t missing transfers: expected %0d more, actual 0",
               $time, board.expected_quanta.size());
    end

    $display("checked %0d bus quanta over %0d transactions", board.checked, board.txn_done);
    $display("%0d address refusals, %0d bytes read", board.refusals, board.bytes_read);
    if (board.errors == 0) begin
      $display("i2c_register_access_master_tb: clean");
    end else begin
      $display("i2c_register_access_master_tb: errors");
    end
    $finish;
  end

endmodule
